// File: hw/rtl/brr_pkg.sv
// Shared types and codes for the broadcast ring with reader heads.
// Used by brr_front, brr_queue, brr_back and the top level; depends on nothing.
`default_nettype none

package brr_pkg;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] id;
        logic [15:0] target;
        logic [63:0] payload;
    } t_cmd;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_NOREG = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_SKIP  = 3'd4;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// File: hw/rtl/brr_front.sv
// Front end: accepts request words, decodes the request kind into a command.
// Depends on brr_pkg.
`default_nettype none

module brr_front
    import brr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_requester_id,
    input  wire logic [15:0] i_target_id,
    input  wire logic [63:0] i_payload,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_op  w_op;

    always_comb begin
        unique case (i_req_type)
            2'd0:    w_op = OP_REG;
            2'd1:    w_op = OP_WRITE;
            2'd2:    w_op = OP_READ;
            default: w_op = OP_NOP;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd.op      <= w_op;
            r_cmd.id      <= i_requester_id;
            r_cmd.target  <= i_target_id;
            r_cmd.payload <= i_payload;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/brr_queue.sv
// Short command queue between front and back ends.
// Depends on brr_pkg.
`default_nettype none

module brr_queue
    import brr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = r_count != CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/brr_back.sv
// Back end: reader table, head memory, ring memory and result register.
// Depends on brr_pkg.
`default_nettype none

module brr_back
    import brr_pkg::*;
#(
    parameter int RING_DEPTH  = 64,
    parameter int MAX_READERS = 6
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    input  wire t_cmd        i_cmd,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [63:0]      o_payload
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CW = $clog2(MAX_READERS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_RING
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [15:0]   r_ident [MAX_READERS];
    logic [RW-1:0] r_slot;
    logic          r_found;
    logic [15:0]   r_id;
    logic          r_ovalid;
    logic [2:0]    r_status;
    logic [63:0]   r_data;

    logic [15:0]   r_ring_target  [RING_DEPTH];
    logic [63:0]   r_ring_payload [RING_DEPTH];
    logic [AW-1:0] r_head_mem     [MAX_READERS];
    logic [AW-1:0] r_head_q;
    logic [15:0]   r_rd_target;
    logic [63:0]   r_rd_payload;

    logic          w_free;
    logic          w_found;
    logic [RW-1:0] w_slot;
    logic [AW-1:0] w_head_next;
    logic          w_head_we;
    logic [RW-1:0] w_head_waddr;
    logic [AW-1:0] w_head_wdata;
    logic          w_head_re;
    logic          w_ring_we;
    logic          w_load;

    assign w_free    = !r_ovalid || i_ready;
    assign o_valid   = r_ovalid;
    assign o_status  = r_status;
    assign o_payload = r_data;

    always_comb begin
        w_found = 1'b0;
        w_slot  = '0;
        for (int i = MAX_READERS - 1; i >= 0; i--) begin
            if ((CW'(i) < r_count) && (r_ident[i] == i_cmd.id)) begin
                w_found = 1'b1;
                w_slot  = RW'(i);
            end
        end
    end

    assign w_head_next = (r_head_q == AW'(RING_DEPTH - 1)) ? '0 : r_head_q + AW'(1);

    always_comb begin
        o_cmd_pop    = 1'b0;
        w_head_we    = 1'b0;
        w_head_waddr = r_slot;
        w_head_wdata = w_head_next;
        w_head_re    = 1'b0;
        w_ring_we    = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_READ) begin
                        o_cmd_pop = 1'b1;
                        w_head_re = 1'b1;
                    end else if (w_free) begin
                        o_cmd_pop = 1'b1;
                        w_load    = 1'b1;
                        if (i_cmd.op == OP_REG && r_count < CW'(MAX_READERS)) begin
                            w_head_we    = 1'b1;
                            w_head_waddr = r_count[RW-1:0];
                            w_head_wdata = '0;
                        end
                        if (i_cmd.op == OP_WRITE) begin
                            w_ring_we = 1'b1;
                        end
                    end
                end
            end
            S_HEAD: begin
                w_load = w_free && (!r_found || r_head_q == r_tail);
            end
            S_RING: begin
                w_head_we = w_free;
                w_load    = w_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[w_head_waddr] <= w_head_wdata;
        end
        if (w_head_re) begin
            r_head_q <= r_head_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring_target[r_tail]  <= i_cmd.target;
            r_ring_payload[r_tail] <= i_cmd.payload;
        end
        r_rd_target  <= r_ring_target[r_head_q];
        r_rd_payload <= r_ring_payload[r_head_q];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_cmd_pop && i_cmd.op == OP_REG
                && r_count < CW'(MAX_READERS)) begin
            r_ident[r_count[RW-1:0]] <= i_cmd.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_slot   <= '0;
            r_found  <= 1'b0;
            r_id     <= '0;
            r_status <= ST_OK;
            r_data   <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.op)
                            OP_READ: begin
                                r_slot  <= w_slot;
                                r_found <= w_found;
                                r_id    <= i_cmd.id;
                                r_state <= S_HEAD;
                            end
                            OP_REG: begin
                                r_data   <= '0;
                                if (r_count < CW'(MAX_READERS)) begin
                                    r_count  <= r_count + CW'(1);
                                    r_status <= ST_OK;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_WRITE: begin
                                r_tail   <= (r_tail == AW'(RING_DEPTH - 1)) ? '0
                                            : r_tail + AW'(1);
                                r_status <= ST_OK;
                                r_data   <= '0;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_data   <= '0;
                            end
                        endcase
                    end
                end
                S_HEAD: begin
                    priority if (!r_found) begin
                        if (w_free) begin
                            r_status <= ST_NOREG;
                            r_data   <= '0;
                            r_state  <= S_IDLE;
                        end
                    end else if (r_head_q == r_tail) begin
                        if (w_free) begin
                            r_status <= ST_EMPTY;
                            r_data   <= '0;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_RING;
                    end
                end
                S_RING: begin
                    if (w_free) begin
                        r_state  <= S_IDLE;
                        if (r_rd_target == 16'd0 || r_rd_target == r_id) begin
                            r_status <= ST_OK;
                            r_data   <= r_rd_payload;
                        end else begin
                            r_status <= ST_SKIP;
                            r_data   <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_READERS))
        else $error("reader count exceeds table size");

    a_ring_needs_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RING) |-> r_found)
        else $error("ring read without a registered reader");

    a_head_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_HEAD) |-> $past(r_state) == S_IDLE)
        else $error("head lookup not started from idle");

    a_tail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= AW'(RING_DEPTH - 1))
        else $error("tail outside ring");

    a_ring_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RING) |-> r_head_q != r_tail)
        else $error("ring read at tail");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/broadcast_ring_with_reader_heads.sv
// Result path: register, write and unused requests pass the front register, the queue and
// the back-end result register; reads also pass a head read, then a ring read (skipped if
// unregistered or empty). Throughput: one register or write word per cycle while the output
// is not stalled and no read is pending; a read holds the back end through its dependent
// head and ring memory reads. Reset (synchronous, active low) clears tail, reader count,
// queue and handshake state; ring and head memories hold no reset and get no clearing pass.
`default_nettype none

module broadcast_ring_with_reader_heads
    import brr_pkg::*;
#(
    parameter int RING_DEPTH  = 64,
    parameter int MAX_READERS = 6
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // requester_id, target_id, payload
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // payload_out
    output logic [2:0]       m_axis_tuser   // status
);

    logic f_valid;
    logic q_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    brr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_req_type     (s_axis_tuser),
        .i_requester_id (s_axis_tdata[15:0]),
        .i_target_id    (s_axis_tdata[31:16]),
        .i_payload      (s_axis_tdata[95:32]),
        .o_cmd_valid    (f_valid),
        .i_cmd_ready    (q_ready),
        .o_cmd          (f_cmd)
    );

    brr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    brr_back #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_payload   (m_axis_tdata)
    );

endmodule

`default_nettype wire
